// File: hdl/b2da_pkg.sv
package b2da_pkg;

    localparam int VALUE_W         = 32;
    localparam int NUM_DIGITS      = 10;
    localparam int BCD_W           = 4 * NUM_DIGITS;
    localparam int WORK_W          = BCD_W + VALUE_W;
    localparam int NUM_STAGES      = 4;
    localparam int STEPS_PER_STAGE = VALUE_W / NUM_STAGES;
    localparam int CHAR_W          = 6;
    localparam int IDX_W           = 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef logic [WORK_W-1:0] t_work;
    typedef logic [BCD_W-1:0]  t_bcd;
    typedef logic [3:0]        t_digit;
    typedef logic [IDX_W-1:0]  t_idx;

    // one shift-add-3 iteration: correct every BCD digit, then shift the binary bit in
    function automatic t_work dabble_step(input t_work w);
        t_work  r;
        t_digit d;
        r = w;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            d = r[VALUE_W + 4*k +: 4];
            if (d >= 4'd5) begin
                r[VALUE_W + 4*k +: 4] = d + 4'd3;
            end
        end
        return {r[WORK_W-2:0], 1'b0};
    endfunction

endpackage

// File: hdl/binary_to_decimal_ascii_core.sv
// Channel   Dir  tdata (low bit up)              tuser  tlast
// s (in)    in   value[31:0]                     -      -
// m (out)   out  digit_char[5:0], 2'b0 pad       -      last_digit
//
// Pipeline: four shift-add-3 stages (eight bits each), then the digit serializer and
// the output register.
// Throughput: one digit per cycle while m is not stalled; an item of n digits (1 to
// MAX_DIGITS, at most 10) holds the serializer until its last digit goes out.
// Reset clears all valid bits; payload registers are not reset.
// A stall on m holds the output register and backs up through the serializer and
// the stage valids; nothing is dropped or repeated.
module binary_to_decimal_ascii_core #(
    parameter int MAX_DIGITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // value[31:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // digit_char[5:0], zero [7:6]
    output logic        o_m_tlast
);

    localparam int LIM = (MAX_DIGITS < 1) ? 1 :
                         ((MAX_DIGITS > b2da_pkg::NUM_DIGITS) ? b2da_pkg::NUM_DIGITS
                                                              : MAX_DIGITS);
    localparam b2da_pkg::t_idx TOP_CAP = b2da_pkg::IDX_W'(LIM - 1);

    logic            stg_valid [b2da_pkg::NUM_STAGES+1];
    logic            stg_ready [b2da_pkg::NUM_STAGES+1];
    b2da_pkg::t_work stg_work  [b2da_pkg::NUM_STAGES+1];

    assign stg_valid[0] = i_s_tvalid;
    assign stg_work[0]  = {{b2da_pkg::BCD_W{1'b0}}, i_s_tdata};
    assign o_s_tready   = stg_ready[0];

    for (genvar g = 0; g < b2da_pkg::NUM_STAGES; g++) begin : g_stage
        b2da_dabble_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[g]),
            .o_ready (stg_ready[g]),
            .i_work  (stg_work[g]),
            .o_valid (stg_valid[g+1]),
            .i_ready (stg_ready[g+1]),
            .o_work  (stg_work[g+1])
        );
    end

    // serializer and output register
    logic                  r_ser_valid;
    b2da_pkg::t_bcd        r_ser_bcd;
    b2da_pkg::t_idx        r_ser_idx;
    logic                  r_out_valid;
    logic [b2da_pkg::CHAR_W-1:0] r_out_char;
    logic                  r_out_last;

    b2da_pkg::t_bcd        load_bcd;
    b2da_pkg::t_idx        load_top;
    b2da_pkg::t_digit      cur_digit;
    logic                  out_free;
    logic                  emit;
    logic                  ser_done;

    assign load_bcd  = stg_work[b2da_pkg::NUM_STAGES][b2da_pkg::WORK_W-1 -: b2da_pkg::BCD_W];
    assign out_free  = !r_out_valid || i_m_tready;
    assign emit      = r_ser_valid && out_free;
    assign ser_done  = emit && (r_ser_idx == '0);
    assign cur_digit = r_ser_bcd[4*r_ser_idx +: 4];

    assign stg_ready[b2da_pkg::NUM_STAGES] = !r_ser_valid || ser_done;

    // find the most significant nonzero digit, keep only the allowed low digits
    always_comb begin
        b2da_pkg::t_idx top;
        top = '0;
        for (int k = 0; k < b2da_pkg::NUM_DIGITS; k++) begin
            if (load_bcd[4*k +: 4] != 4'd0) begin
                top = b2da_pkg::IDX_W'(k);
            end
        end
        load_top = (top > TOP_CAP) ? TOP_CAP : top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_valid <= 1'b0;
        end else if (stg_ready[b2da_pkg::NUM_STAGES]) begin
            r_ser_valid <= stg_valid[b2da_pkg::NUM_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_ready[b2da_pkg::NUM_STAGES] && stg_valid[b2da_pkg::NUM_STAGES]) begin
            r_ser_bcd <= load_bcd;
            r_ser_idx <= load_top;
        end else if (emit) begin
            r_ser_idx <= r_ser_idx - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_ser_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_char <= b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(cur_digit);
            r_out_last <= (r_ser_idx == '0);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_char};
    assign o_m_tlast  = r_out_last;

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[5:0] >= 6'd48 && o_m_tdata[5:0] <= 6'd57))
        else $error("digit character out of range");

    a_idx_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ser_valid |-> (r_ser_idx <= TOP_CAP))
        else $error("serializer index beyond digit limit");

    a_run_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_ser_idx != '0) |=> r_ser_valid)
        else $error("serializer dropped a run before its last digit");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !r_ser_valid) |=> !o_m_tvalid)
        else $error("output repeated a digit");

endmodule

// File: hdl/b2da_dabble_stage.sv
module b2da_dabble_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  b2da_pkg::t_work     i_work,
    output logic                o_valid,
    input  logic                i_ready,
    output b2da_pkg::t_work     o_work
);

    logic            r_valid;
    b2da_pkg::t_work r_work;
    b2da_pkg::t_work n_work;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_work  = r_work;

    always_comb begin
        n_work = i_work;
        for (int s = 0; s < b2da_pkg::STEPS_PER_STAGE; s++) begin
            n_work = b2da_pkg::dabble_step(n_work);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

endmodule
